/* src/ppid_pkg.sv */
// shared constants, types and arithmetic helpers for the position pid block
// no dependencies; used by position_pid_with_averaged_derivative_top
package ppid_pkg;

  // derivative averaging window
  localparam int DERIV_TAPS = 10;

  // stream widths
  localparam int POS_W  = 32;
  localparam int ERR_W  = 16;
  localparam int IN_W   = 2 * POS_W;
  localparam int OUT_W  = POS_W + ERR_W;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P         = 3'd0,
    CFG_GAIN_D         = 3'd1,
    CFG_GAIN_I         = 3'd2,
    CFG_SCALE_SHIFT    = 3'd3,
    CFG_INTEGRAL_LIMIT = 3'd4,
    CFG_DRIVE_OFFSET   = 3'd5
  } cfg_idx_e;

  localparam logic signed [15:0] GAIN_P_RST = 16'sd10;
  localparam logic signed [15:0] GAIN_D_RST = 16'sd40;
  localparam logic signed [15:0] GAIN_I_RST = 16'sd0;
  localparam logic        [4:0]  SHIFT_RST  = 5'd3;
  localparam logic        [14:0] LIMIT_RST  = 15'h7fff;
  localparam logic signed [15:0] OFFSET_RST = 16'sd0;

  // running sum of the window and its magnitude
  localparam int SUM_W  = POS_W + $clog2(DERIV_TAPS);
  localparam int MAG_W  = SUM_W;
  localparam int HALF_W = MAG_W / 2;
  localparam int HI_W   = MAG_W - HALF_W;

  // reciprocal of the window length, rounded up, scaled by 2^MAG_W
  localparam longint unsigned RECIP_L =
    ((64'd1 << MAG_W) + 64'(DERIV_TAPS) - 64'd1) / 64'(DERIV_TAPS);
  localparam int RECIP_W = $clog2(RECIP_L + 64'd1);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  localparam int PPL_W = HALF_W + RECIP_W;
  localparam int PPH_W = HI_W + RECIP_W;
  localparam int TOT_W = MAG_W + RECIP_W + 1;
  localparam int REM_W = MAG_W + 5;

  // pipeline stage positions
  localparam int ST_IN      = 0;
  localparam int ST_ERR     = 1;
  localparam int ST_MUL     = 2;
  localparam int ST_SHIFT   = 3;
  localparam int ST_HIST    = 4;
  localparam int ST_RECIP   = 5;
  localparam int ST_QEST    = 6;
  localparam int ST_DAVG    = 7;
  localparam int ST_PD      = 8;
  localparam int ST_PID     = 9;
  localparam int ST_OUT     = 10;
  localparam int NUM_STAGES = 11;

  localparam logic signed [ERR_W-1:0] ERR_MAX = 16'sh7fff;
  localparam logic signed [ERR_W-1:0] ERR_MIN = 16'sh8000;

  // right shift with the magnitude rounded toward zero
  function automatic logic signed [33:0] shift_to_zero(input logic signed [33:0] v,
                                                       input logic [4:0] s);
    logic signed [33:0] bias;
    bias = v[33] ? ((34'sd1 <<< s) - 34'sd1) : 34'sd0;
    return (v + bias) >>> s;
  endfunction

  function automatic logic signed [ERR_W-1:0] sat16(input logic signed [32:0] v);
    logic signed [ERR_W-1:0] r;
    if (v > 33'sd32767) begin
      r = ERR_MAX;
    end else if (v < -33'sd32768) begin
      r = ERR_MIN;
    end else begin
      r = v[ERR_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic signed [32:0] s;
    logic signed [31:0] r;
    s = 33'(a) + 33'(b);
    if (s[32] != s[31]) begin
      r = s[32] ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

endpackage

/* src/position_pid_with_averaged_derivative_top.sv */
// position pid with a windowed derivative average, one joint, as an 11-stage pipeline
// depends on ppid_pkg
//
//  port group  dir  bits  beat contents (lowest bit first)
//  s_axis      in   64    target_position [31:0], measured_position [63:32]
//  m_axis      out  48    drive [31:0], clamped_error [47:32]
//  cfg         in   3+16  register index, write data
//
// one beat per clock while m_axis does not stall; a result shows on m_axis from the stage-10 output register
// the pipeline has eleven stages, with the divide-by-window split over three stages
// integral and window state close their loops inside a single stage, so beats can follow back to back
// reset clears stage valid bits, accumulator, window history and last error, and loads config defaults
// a stage holds only while every later stage is full, so bubbles collapse under m_axis backpressure
module position_pid_with_averaged_derivative_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ppid_pkg::IN_W-1:0]     s_axis_tdata,   // target_position, measured_position
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ppid_pkg::OUT_W-1:0]    m_axis_tdata,   // drive, clamped_error
  input  logic                          cfg_we_i,
  input  logic [ppid_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ppid_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int NS = ppid_pkg::NUM_STAGES;
  localparam int T  = ppid_pkg::DERIV_TAPS;

  // ---------------- configuration registers ----------------
  logic signed [15:0] gain_p_q, gain_d_q, gain_i_q, offset_q;
  logic        [4:0]  shift_q;
  logic        [14:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= ppid_pkg::GAIN_P_RST;
      gain_d_q <= ppid_pkg::GAIN_D_RST;
      gain_i_q <= ppid_pkg::GAIN_I_RST;
      shift_q  <= ppid_pkg::SHIFT_RST;
      limit_q  <= ppid_pkg::LIMIT_RST;
      offset_q <= ppid_pkg::OFFSET_RST;
    end else if (cfg_we_i) begin
      case (ppid_pkg::cfg_idx_e'(cfg_index_i))
        ppid_pkg::CFG_GAIN_P:         gain_p_q <= cfg_data_i;
        ppid_pkg::CFG_GAIN_D:         gain_d_q <= cfg_data_i;
        ppid_pkg::CFG_GAIN_I:         gain_i_q <= cfg_data_i;
        ppid_pkg::CFG_SCALE_SHIFT:    shift_q  <= cfg_data_i[4:0];
        ppid_pkg::CFG_INTEGRAL_LIMIT: limit_q  <= cfg_data_i[14:0];
        ppid_pkg::CFG_DRIVE_OFFSET:   offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic [NS-1:0] v_q, adv, in_valid, take;

  always_comb begin
    adv[NS-1] = !v_q[NS-1] || m_axis_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign in_valid      = {v_q[NS-2:0], s_axis_tvalid};
  assign take          = adv & in_valid;
  assign s_axis_tready = adv[ppid_pkg::ST_IN];
  assign m_axis_tvalid = v_q[ppid_pkg::ST_OUT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (adv[k]) begin
          v_q[k] <= in_valid[k];
        end
      end
    end
  end

  // ---------------- stage 0: input register ----------------
  logic signed [31:0] tgt0_q, meas0_q;

  always_ff @(posedge clk_i) begin
    if (take[ppid_pkg::ST_IN]) begin
      tgt0_q  <= s_axis_tdata[31:0];
      meas0_q <= s_axis_tdata[63:32];
    end
  end

  // ---------------- stage 1: error and error step ----------------
  logic signed [32:0] diff_c;
  logic signed [15:0] err_c, last_err_q, err1_q;
  logic signed [16:0] delta_c, delta1_q;

  assign diff_c  = 33'(tgt0_q) - 33'(meas0_q);
  assign err_c   = ppid_pkg::sat16(diff_c);
  assign delta_c = 17'(err_c) - 17'(last_err_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
    end else if (take[ppid_pkg::ST_ERR]) begin
      last_err_q <= err_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take[ppid_pkg::ST_ERR]) begin
      err1_q   <= err_c;
      delta1_q <= delta_c;
    end
  end

  // ---------------- stage 2: gain products ----------------
  logic signed [31:0] pprod2_q, iprod2_q;
  logic signed [32:0] dprod2_q;
  logic signed [15:0] err2_q;

  always_ff @(posedge clk_i) begin
    if (take[ppid_pkg::ST_MUL]) begin
      pprod2_q <= 32'(err1_q) * 32'(gain_p_q);
      dprod2_q <= 33'(delta1_q) * 33'(gain_d_q);
      iprod2_q <= 32'(err1_q) * 32'(gain_i_q);
      err2_q   <= err1_q;
    end
  end

  // ---------------- stage 3: scaling and integral loop ----------------
  logic signed [33:0] psh_c, dsh_c, ish_c;
  logic signed [31:0] acc_q, acc_sum_c, acc_d;
  logic signed [15:0] ipc_c, ip_c;
  logic signed [16:0] lim_s;
  logic signed [31:0] p3_q, d3_q;
  logic signed [15:0] ip3_q, err3_q;

  assign psh_c     = ppid_pkg::shift_to_zero(34'(pprod2_q), shift_q);
  assign dsh_c     = ppid_pkg::shift_to_zero(34'(dprod2_q), shift_q);
  assign acc_sum_c = acc_q + iprod2_q;   // wraps
  assign ish_c     = ppid_pkg::shift_to_zero(34'(acc_sum_c), shift_q);
  assign ipc_c     = ppid_pkg::sat16(ish_c[32:0]);
  assign lim_s     = $signed({2'b00, limit_q});

  always_comb begin
    if (17'(ipc_c) >= lim_s) begin
      ip_c  = 16'(lim_s);
      acc_d = 32'(lim_s);
    end else if (17'(ipc_c) < -lim_s) begin
      ip_c  = 16'(-lim_s);
      acc_d = 32'(-lim_s);
    end else begin
      ip_c  = ipc_c;
      acc_d = acc_sum_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (take[ppid_pkg::ST_SHIFT]) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take[ppid_pkg::ST_SHIFT]) begin
      p3_q   <= psh_c[31:0];
      d3_q   <= dsh_c[31:0];
      ip3_q  <= ip_c;
      err3_q <= err2_q;
    end
  end

  // ---------------- stage 4: derivative window ----------------
  logic signed [31:0] hist_q [T];
  logic signed [ppid_pkg::SUM_W-1:0] sum_q, sum_d;
  logic [ppid_pkg::MAG_W-1:0] mag_c, mag4_q;
  logic neg4_q;
  logic signed [31:0] p4_q;
  logic signed [15:0] ip4_q, err4_q;

  assign sum_d = sum_q + ppid_pkg::SUM_W'(d3_q) - ppid_pkg::SUM_W'(hist_q[T-1]);
  assign mag_c = sum_d[ppid_pkg::SUM_W-1] ? ppid_pkg::MAG_W'(-sum_d)
                                          : ppid_pkg::MAG_W'(sum_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      for (int k = 0; k < T; k++) begin
        hist_q[k] <= '0;
      end
    end else if (take[ppid_pkg::ST_HIST]) begin
      sum_q <= sum_d;
      for (int k = T - 1; k > 0; k--) begin
        hist_q[k] <= hist_q[k-1];
      end
      hist_q[0] <= d3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take[ppid_pkg::ST_HIST]) begin
      mag4_q <= mag_c;
      neg4_q <= sum_d[ppid_pkg::SUM_W-1];
      p4_q   <= p3_q;
      ip4_q  <= ip3_q;
      err4_q <= err3_q;
    end
  end

  // ---------------- stage 5: reciprocal partial products ----------------
  logic [ppid_pkg::PPL_W-1:0] pplo5_q;
  logic [ppid_pkg::PPH_W-1:0] pphi5_q;
  logic [ppid_pkg::MAG_W-1:0] mag5_q;
  logic neg5_q;
  logic signed [31:0] p5_q;
  logic signed [15:0] ip5_q, err5_q;

  always_ff @(posedge clk_i) begin
    if (take[ppid_pkg::ST_RECIP]) begin
      pplo5_q <= ppid_pkg::PPL_W'(mag4_q[ppid_pkg::HALF_W-1:0])
               * ppid_pkg::PPL_W'(ppid_pkg::RECIP);
      pphi5_q <= ppid_pkg::PPH_W'(mag4_q[ppid_pkg::MAG_W-1:ppid_pkg::HALF_W])
               * ppid_pkg::PPH_W'(ppid_pkg::RECIP);
      mag5_q  <= mag4_q;
      neg5_q  <= neg4_q;
      p5_q    <= p4_q;
      ip5_q   <= ip4_q;
      err5_q  <= err4_q;
    end
  end

  // ---------------- stage 6: quotient estimate ----------------
  logic [ppid_pkg::TOT_W-1:0] tot_c, tot_sh_c;
  logic [ppid_pkg::MAG_W-1:0] q6_q, mag6_q;
  logic neg6_q;
  logic signed [31:0] p6_q;
  logic signed [15:0] ip6_q, err6_q;

  assign tot_c    = (ppid_pkg::TOT_W'(pphi5_q) << ppid_pkg::HALF_W)
                  + ppid_pkg::TOT_W'(pplo5_q);
  assign tot_sh_c = tot_c >> ppid_pkg::MAG_W;

  always_ff @(posedge clk_i) begin
    if (take[ppid_pkg::ST_QEST]) begin
      q6_q   <= tot_sh_c[ppid_pkg::MAG_W-1:0];
      mag6_q <= mag5_q;
      neg6_q <= neg5_q;
      p6_q   <= p5_q;
      ip6_q  <= ip5_q;
      err6_q <= err5_q;
    end
  end

  // ---------------- stage 7: quotient correction and sign ----------------
  // the estimate is at most one too large
  logic [ppid_pkg::REM_W-1:0] rem_c;
  logic [ppid_pkg::MAG_W-1:0] qc_c;
  logic signed [31:0] davg_c, davg7_q, p7_q;
  logic signed [15:0] ip7_q, err7_q;

  assign rem_c  = ppid_pkg::REM_W'(mag6_q)
                - ppid_pkg::REM_W'(q6_q) * ppid_pkg::REM_W'(T);
  assign qc_c   = rem_c[ppid_pkg::REM_W-1] ? (q6_q - 1'b1) : q6_q;
  assign davg_c = neg6_q ? -$signed(qc_c[31:0]) : $signed(qc_c[31:0]);

  always_ff @(posedge clk_i) begin
    if (take[ppid_pkg::ST_DAVG]) begin
      davg7_q <= davg_c;
      p7_q    <= p6_q;
      ip7_q   <= ip6_q;
      err7_q  <= err6_q;
    end
  end

  // ---------------- stages 8 to 10: saturating output sums ----------------
  logic signed [31:0] pd8_q, pid9_q, drive10_q;
  logic signed [15:0] ip8_q, err8_q, err9_q, err10_q;

  always_ff @(posedge clk_i) begin
    if (take[ppid_pkg::ST_PD]) begin
      pd8_q  <= ppid_pkg::sat_add32(p7_q, davg7_q);
      ip8_q  <= ip7_q;
      err8_q <= err7_q;
    end
    if (take[ppid_pkg::ST_PID]) begin
      pid9_q <= ppid_pkg::sat_add32(pd8_q, 32'(ip8_q));
      err9_q <= err8_q;
    end
    if (take[ppid_pkg::ST_OUT]) begin
      drive10_q <= ppid_pkg::sat_add32(pid9_q, 32'(offset_q));
      err10_q   <= err9_q;
    end
  end

  assign m_axis_tdata = {err10_q, drive10_q};

  // ---------------- checks ----------------
  logic signed [ppid_pkg::SUM_W-1:0] chk_sum;

  always_comb begin
    chk_sum = '0;
    for (int k = 0; k < T; k++) begin
      chk_sum = chk_sum + ppid_pkg::SUM_W'(hist_q[k]);
    end
  end

  a_window_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q == chk_sum)
    else $error("running window sum out of step with history");

  a_last_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take[ppid_pkg::ST_ERR] |=> last_err_q == err1_q)
    else $error("last error not tracking the error stage");

  a_int_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take[ppid_pkg::ST_SHIFT] |=>
      (17'(ip3_q) <= $past(lim_s)) && (17'(ip3_q) >= -$past(lim_s)))
    else $error("integral term beyond its limit");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[ppid_pkg::ST_IN] |-> s_axis_tready)
    else $error("input stalled with an empty input stage");

endmodule

/* bench/ppid_drive_checker.sv */
`timescale 1ns / 1ps
// checker for the position pid block: snoops the position, result and config channels,
// predicts drive and clamped error for every tick and compares results in order
// depends on ppid_pkg
module ppid_drive_checker
  import ppid_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_W-1:0]       s_axis_tdata,   // target_position, measured_position
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_W-1:0]      m_axis_tdata,   // drive, clamped_error
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    outstanding_o
);

  localparam longint DRIVE_MAX = 64'sd2147483647;
  localparam longint DRIVE_MIN = -64'sd2147483648;
  localparam longint ERR_HI    = 64'sd32767;
  localparam longint ERR_LO    = -64'sd32768;

  // first member lands in the upper bits: error over drive
  typedef struct packed {
    logic signed [15:0] error;
    logic signed [31:0] drive;
  } tick_result_t;

  // controller settings as last written
  logic signed [15:0] kp, kd, ki, offset;
  logic        [4:0]  shamt;
  logic        [14:0] ilimit;

  // loop state
  longint prev_err;
  int     deriv_hist [DERIV_TAPS];
  int     integ_acc;

  tick_result_t due_q[$];
  int           due_count;
  int           fails = 0;

  assign fail_count_o  = fails;
  assign outstanding_o = due_count;

  // sign-magnitude shift, rounds toward zero
  function automatic longint shift_mag(input longint v, input int unsigned s);
    longint m;
    m = (v < 0) ? -v : v;
    m = m >>> s;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic tick_result_t control_tick(input logic signed [31:0] tgt,
                                                input logic signed [31:0] meas);
    longint       err, p, d, dsum, ip, acc, pd, pid, drv;
    int           acc_w;
    int           k;
    tick_result_t r;
    err = clip(longint'(tgt) - longint'(meas), ERR_LO, ERR_HI);
    p   = shift_mag(err * longint'(kp), shamt);
    d   = shift_mag((err - prev_err) * longint'(kd), shamt);
    for (k = DERIV_TAPS - 1; k > 0; k--) begin
      deriv_hist[k] = deriv_hist[k-1];
    end
    deriv_hist[0] = int'(d);
    dsum = 0;
    for (k = 0; k < DERIV_TAPS; k++) begin
      dsum += longint'(deriv_hist[k]);
    end
    d = dsum / DERIV_TAPS;
    // accumulator wraps at 32 bits
    acc_w = integ_acc + int'(err * longint'(ki));
    acc   = longint'(acc_w);
    ip    = clip(shift_mag(acc, shamt), ERR_LO, ERR_HI);
    if (ip >= longint'(ilimit)) begin
      ip  = longint'(ilimit);
      acc = longint'(ilimit);
    end else if (ip < -longint'(ilimit)) begin
      ip  = -longint'(ilimit);
      acc = -longint'(ilimit);
    end
    integ_acc = int'(acc);
    prev_err  = err;
    pd  = clip(p + d, DRIVE_MIN, DRIVE_MAX);
    pid = clip(pd + ip, DRIVE_MIN, DRIVE_MAX);
    drv = clip(pid + longint'(offset), DRIVE_MIN, DRIVE_MAX);
    r.drive = 32'(drv);
    r.error = 16'(err);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tick_result_t want, got;
    int k;
    if (!rst_ni) begin
      kp       = GAIN_P_RST;
      kd       = GAIN_D_RST;
      ki       = GAIN_I_RST;
      shamt    = SHIFT_RST;
      ilimit   = LIMIT_RST;
      offset   = OFFSET_RST;
      prev_err = 0;
      for (k = 0; k < DERIV_TAPS; k++) begin
        deriv_hist[k] = 0;
      end
      integ_acc = 0;
      due_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (due_q.size() == 0) begin
          $error("result beat with no tick outstanding: drive %0d, clamped_error %0d",
                 got.drive, got.error);
          fails++;
        end else begin
          want = due_q.pop_front();
          if (got.drive !== want.drive) begin
            $error("drive: expected %0d, got %0d", want.drive, got.drive);
            fails++;
          end
          if (got.error !== want.error) begin
            $error("clamped_error: expected %0d, got %0d", want.error, got.error);
            fails++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        due_q.push_back(control_tick(s_axis_tdata[31:0], s_axis_tdata[63:32]));
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_GAIN_P:         kp     = cfg_data_i;
          CFG_GAIN_D:         kd     = cfg_data_i;
          CFG_GAIN_I:         ki     = cfg_data_i;
          CFG_SCALE_SHIFT:    shamt  = cfg_data_i[4:0];
          CFG_INTEGRAL_LIMIT: ilimit = cfg_data_i[14:0];
          CFG_DRIVE_OFFSET:   offset = cfg_data_i;
          default: ;
        endcase
      end
    end
    due_count = due_q.size();
  end

endmodule

/* bench/position_pid_with_averaged_derivative_top_tb.sv */
`timescale 1ns / 1ps
// top of the position pid bench: clock, reset, position and config stimulus, result stalls
// depends on ppid_pkg, position_pid_with_averaged_derivative_top and ppid_drive_checker
module position_pid_with_averaged_derivative_top_tb;
  import ppid_pkg::*;

  localparam int CLK_HALF_NS      = 2;
  localparam int RESET_CYCLES     = 6;
  localparam int DIRECTED_PAIRS   = 13;
  localparam int NUM_PHASES       = 10;
  localparam int RANDOM_PER_PHASE = 116;
  localparam int DRAIN_CYCLES     = 12;
  localparam int IDLE_PCT         = 16;
  // early in a random phase, so plenty of beats are still to come
  localparam int HOLD_AT_ITEM     = 384;
  localparam int HOLD_CYCLES      = 300;
  localparam int RX_CALM_FROM     = 1200;
  localparam int RX_CALM_TO       = 1500;
  localparam int TX_CALM_FROM     = 500;
  localparam int TX_CALM_TO       = 650;

  // indexes past the register list, must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata;   // target_position, measured_position
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_W-1:0]      m_axis_tdata;   // drive, clamped_error
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int fail_count;
  int outstanding;
  int item_no;
  int last_tgt;
  int last_meas;

  position_pid_with_averaged_derivative_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  ppid_drive_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF_NS) clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("position_pid_with_averaged_derivative_top test failed");
    $finish;
  end

  // result side: random stalls, one long hold-off while positions keep coming, a calm window
  initial begin
    int cyc;
    int hold_left;
    bit held;
    cyc       = 0;
    hold_left = 0;
    held      = 1'b0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (!held && item_no >= HOLD_AT_ITEM && s_axis_tvalid) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (cyc >= RX_CALM_FROM && cyc < RX_CALM_TO) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
  endtask

  task automatic program_phase(input int ph);
    logic [15:0] gp, gd, gi, off;
    logic [4:0]  sh;
    logic [14:0] lim;
    gp  = 16'($urandom);
    gd  = 16'($urandom);
    gi  = $urandom_range(0, 1) ? 16'($urandom) : 16'(int'($urandom_range(0, 64)) - 32);
    sh  = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 12));
    lim = 15'($urandom);
    off = 16'($urandom);
    case (ph)
      1: begin
        gp = 16'h7fff; gd = 16'h7fff; gi = 16'h7fff;
        sh = 5'd0; lim = 15'h7fff; off = 16'h7fff;
      end
      2: begin
        gp = 16'h8000; gd = 16'h8000; gi = 16'h8000;
        sh = 5'd31; lim = 15'd0; off = 16'h8000;
      end
      // zero limit: a non-negative integral term keeps clearing the accumulator
      3: begin
        sh  = 5'($urandom_range(0, 4));
        lim = 15'd0;
      end
      default: ;
    endcase
    write_reg(CFG_GAIN_P, gp);
    write_reg(CFG_GAIN_D, gd);
    write_reg(CFG_GAIN_I, gi);
    write_reg(CFG_SCALE_SHIFT, {11'd0, sh});
    write_reg(CFG_INTEGRAL_LIMIT, {1'b0, lim});
    write_reg(CFG_DRIVE_OFFSET, off);
    if (ph == 4) begin
      write_reg(CFG_SPARE_6, 16'($urandom));
      write_reg(CFG_SPARE_7, 16'($urandom));
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_pair(input int tgt, input int meas);
    int idle;
    idle = 0;
    if (item_no < TX_CALM_FROM || item_no >= TX_CALM_TO) begin
      while ($urandom_range(0, 99) < IDLE_PCT) idle++;
    end
    if (idle > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {meas, tgt};
    do @(posedge clk_i); while (!s_axis_tready);
    item_no++;
    last_tgt  = tgt;
    last_meas = meas;
  endtask

  task automatic directed_pair(input int n, output int tgt, output int meas);
    tgt  = 0;
    meas = 0;
    case (n)
      1:  tgt  = 32767;
      2:  meas = 32768;
      3:  tgt  = 40000;
      4:  meas = 40000;
      // difference overflows 32 bits both ways
      5:  begin tgt = int'(32'h7fffffff); meas = int'(32'h80000000); end
      6:  begin tgt = int'(32'h80000000); meas = int'(32'h7fffffff); end
      7:  tgt  = 1;
      8:  tgt  = -1;
      9:  tgt  = -7;
      10: tgt  = 5;
      11: begin tgt = 100; meas = -100; end
      12: begin tgt = int'(32'h80000000); meas = int'(32'h80000000); end
      default: ;
    endcase
  endtask

  task automatic random_pair(output int tgt, output int meas);
    int sel;
    int step;
    sel = $urandom_range(0, 19);
    if (sel < 3) begin
      tgt  = $urandom;
      meas = $urandom;
    end else if (sel < 10) begin
      meas = last_meas + int'($urandom_range(0, 200)) - 100;
      tgt  = meas + int'($urandom_range(0, 80000)) - 40000;
    end else if (sel < 14) begin
      meas = last_meas + int'($urandom_range(0, 200)) - 100;
      tgt  = meas + int'($urandom_range(0, 128)) - 64;
    end else if (sel < 16) begin
      // right at the edges of the error clamp
      meas = $urandom;
      case ($urandom_range(0, 3))
        0:       tgt = meas + 32767;
        1:       tgt = meas + 32768;
        2:       tgt = meas - 32768;
        default: tgt = meas - 32769;
      endcase
    end else begin
      // same error again, lets the integral run up to its limit
      step = int'($urandom_range(0, 20)) - 10;
      meas = last_meas + step;
      tgt  = last_tgt + step;
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int tgt, meas, n, ph;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= CFG_GAIN_P;
    cfg_data_i    <= '0;
    item_no   = 0;
    last_tgt  = 0;
    last_meas = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        wait_drained();
        program_phase(ph);
      end
      if (ph < 2) begin
        for (n = 0; n < DIRECTED_PAIRS; n++) begin
          directed_pair(n, tgt, meas);
          send_pair(tgt, meas);
        end
      end else begin
        for (n = 0; n < RANDOM_PER_PHASE; n++) begin
          random_pair(tgt, meas);
          send_pair(tgt, meas);
        end
      end
      s_axis_tvalid <= 1'b0;
    end
    wait_drained();
    if (fail_count == 0) begin
      $display("position_pid_with_averaged_derivative_top test passed");
    end else begin
      $display("position_pid_with_averaged_derivative_top test failed");
    end
    $finish;
  end

endmodule
